@@ hw/rtl/ket_pkg.sv @@
// Shared types, codes and sizes for the keyed entry table.
package ket_pkg;

    // Default table depth
    localparam int KET_ENTRIES = 16;

    // Field widths
    localparam int KET_WORD_W  = 64;
    localparam int KET_KEY_W   = 4 * KET_WORD_W;
    localparam int KET_BYTES_W = 64;
    localparam int KET_PATH_W  = 16;
    localparam int KET_TOTAL_W = 5;

    // Request codes
    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_PUT    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_RSVD   = 2'd3
    } t_req_type;

    // Result status codes
    typedef enum logic [1:0] {
        ST_HIT       = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // One stored entry, as kept in the entry RAM
    typedef struct packed {
        logic [KET_KEY_W-1:0]   key;
        logic [KET_BYTES_W-1:0] bytes;
        logic [KET_PATH_W-1:0]  path;
    } t_entry;

    localparam int KET_ENTRY_W = $bits(t_entry);

    // Finished result handed from the sequencer to the output stage
    typedef struct packed {
        logic                   valid;
        logic                   found;
        t_status                status;
        logic [KET_BYTES_W-1:0] bytes;
        logic [KET_PATH_W-1:0]  path;
        logic [KET_TOTAL_W-1:0] total;
    } t_done;

endpackage

@@ hw/rtl/ket_if.sv @@
// Request and response channel interfaces of the keyed entry table.
interface ket_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] key_word_0;
    logic [63:0] key_word_1;
    logic [63:0] key_word_2;
    logic [63:0] key_word_3;
    logic [15:0] path_handle;
    logic [63:0] byte_count;

    modport source (
        output valid, req_type, key_word_0, key_word_1, key_word_2, key_word_3,
               path_handle, byte_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_word_0, key_word_1, key_word_2, key_word_3,
               path_handle, byte_count,
        output ready
    );
endinterface

interface ket_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [1:0]  status;
    logic [63:0] byte_count_out;
    logic [15:0] path_handle_out;
    logic [4:0]  entry_total;

    modport source (
        output valid, found, status, byte_count_out, path_handle_out, entry_total,
        input  ready
    );
    modport sink (
        input  valid, found, status, byte_count_out, path_handle_out, entry_total,
        output ready
    );
endinterface

@@ hw/rtl/ket_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ket_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ket_seq.sv @@
// Request sequencer: scans the entry RAM, updates, appends and compacts.
module ket_seq import ket_pkg::*; #(
    parameter int ENTRIES = KET_ENTRIES,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ket_req_if.sink                i_req,
    output logic                   o_ram_we,
    output logic [IDX_W-1:0]       o_ram_waddr,
    output logic [KET_ENTRY_W-1:0] o_ram_wdata,
    output logic [IDX_W-1:0]       o_ram_raddr,
    input  logic [KET_ENTRY_W-1:0] i_ram_rdata,
    output t_done                  o_done,
    input  logic                   i_out_free
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_MISS = 6'b000100,
        S_MVRD = 6'b001000,
        S_MVWR = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    t_req_type              r_type;
    logic [KET_KEY_W-1:0]   r_key;
    logic [KET_BYTES_W-1:0] r_bytes;
    logic [KET_PATH_W-1:0]  r_path;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_found, n_found;
    t_status                r_status, n_status;
    logic [KET_BYTES_W-1:0] r_res_bytes, n_res_bytes;
    logic [KET_PATH_W-1:0]  r_res_path, n_res_path;

    t_entry                 rd_entry;
    t_entry                 wr_entry;
    logic                   accept;
    logic                   key_hit;
    logic                   at_last;
    logic [IDX_W-1:0]       last_idx;

    assign rd_entry    = t_entry'(i_ram_rdata);
    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign key_hit     = (rd_entry.key == r_key);
    assign at_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign last_idx    = IDX_W'(r_count - CNT_W'(1));

    // Latch the request on acceptance
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type  <= t_req_type'(i_req.req_type);
            r_key   <= {i_req.key_word_3, i_req.key_word_2,
                        i_req.key_word_1, i_req.key_word_0};
            r_bytes <= i_req.byte_count;
            r_path  <= i_req.path_handle;
        end
    end

    // Sequence one request: scan, then update, append or compact
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_found     = r_found;
        n_status    = r_status;
        n_res_bytes = r_res_bytes;
        n_res_path  = r_res_path;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        wr_entry    = rd_entry;
        o_ram_raddr = r_idx + IDX_W'(1);

        case (r_state)
            S_IDLE: begin
                // Prefetch entry zero so the scan starts with data in hand
                o_ram_raddr = '0;
                if (accept) begin
                    n_idx = '0;
                    if (i_req.req_type inside {REQ_LOOKUP, REQ_PUT, REQ_DELETE} &&
                        r_count != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_MISS;
                    end
                end
            end
            S_SCAN: begin
                // Compare the entry read last cycle, prefetch the next one
                if (key_hit) begin
                    n_found     = 1'b1;
                    n_status    = ST_HIT;
                    n_res_bytes = rd_entry.bytes;
                    n_res_path  = rd_entry.path;
                    n_state     = S_DONE;
                    if (r_type == REQ_PUT) begin
                        wr_entry.key   = r_key;
                        wr_entry.bytes = r_bytes;
                        wr_entry.path  = r_path;
                        o_ram_we       = 1'b1;
                        n_res_bytes    = r_bytes;
                        n_res_path     = r_path;
                    end else if (r_type == REQ_DELETE) begin
                        if (at_last) begin
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            n_state = S_MVRD;
                        end
                    end
                end else if (at_last) begin
                    n_state = S_MISS;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_MISS: begin
                // Append on put, otherwise report not found
                n_found     = 1'b0;
                n_res_bytes = '0;
                n_res_path  = '0;
                n_state     = S_DONE;
                if (r_type == REQ_PUT) begin
                    if (r_count >= CNT_W'(ENTRIES)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_entry.key   = r_key;
                        wr_entry.bytes = r_bytes;
                        wr_entry.path  = r_path;
                        o_ram_we       = 1'b1;
                        o_ram_waddr    = IDX_W'(r_count);
                        n_count        = r_count + CNT_W'(1);
                        n_status       = ST_INSERTED;
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            S_MVRD: begin
                // Fetch the highest used entry to fill the hole
                o_ram_raddr = last_idx;
                n_state     = S_MVWR;
            end
            S_MVWR: begin
                // Move it into the hole and shrink the table
                o_ram_we = 1'b1;
                n_count  = r_count - CNT_W'(1);
                n_state  = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output stage takes it
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ram_wdata = KET_ENTRY_W'(wr_entry);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_status    <= n_status;
        r_res_bytes <= n_res_bytes;
        r_res_path  <= n_res_path;
    end

    assign o_done.valid  = (r_state == S_DONE);
    assign o_done.found  = r_found;
    assign o_done.status = r_status;
    assign o_done.bytes  = r_res_bytes;
    assign o_done.path   = r_res_path;
    assign o_done.total  = KET_TOTAL_W'(r_count);

    // The table never holds more than its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond table depth");

    // An append only happens while there is room
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MISS && o_ram_we) |-> (r_count < CNT_W'(ENTRIES)))
        else $error("append into a full table");

    // A compaction move needs at least two used entries
    a_move_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MVRD) |-> (r_count > CNT_W'(1)))
        else $error("compaction move with fewer than two entries");

    // An accepted transaction goes straight to scan or miss handling
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN || r_state == S_MISS))
        else $error("accepted transaction did not start");

endmodule

@@ hw/rtl/keyed_entry_table_core.sv @@
// Top level of the keyed entry table: sequencer, entry RAM and output register.
//
// Usage:
//   i_req carries one request transaction: lookup, put or delete of a 256-bit
//   key given as four 64-bit words, with a byte count and a path handle that
//   only a put stores. o_rsp returns exactly one result transaction for each
//   request, in order: found, status, stored byte count and path handle, and
//   the number of used entries after the request.
//   Requests are handled one at a time. From acceptance the sequencer scans
//   the used entries one entry per cycle through the RAM read port; a hit
//   ends the scan, and when all used entries miss the miss state appends or
//   reports not found. A delete that fills its hole from the last entry adds
//   the move read and move write states. The next request can be accepted in
//   the cycle after the result is loaded into the output register.
//   At reset the table is empty: the used count clears and no RAM clearing
//   pass is needed, as only entries below the used count are compared or moved.
//   A result waits in the output register while the receiver stalls; the
//   next request is accepted meanwhile, and its result waits in the
//   sequencer until the output register is free.
module keyed_entry_table_core import ket_pkg::*; #(
    parameter int ENTRIES = KET_ENTRIES,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ket_req_if.sink   i_req,
    ket_rsp_if.source o_rsp
);

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [KET_ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [KET_ENTRY_W-1:0] ram_rdata;
    t_done                  done;
    logic                   out_free;

    logic                   r_out_valid;
    logic                   r_out_found;
    t_status                r_out_status;
    logic [KET_BYTES_W-1:0] r_out_bytes;
    logic [KET_PATH_W-1:0]  r_out_path;
    logic [KET_TOTAL_W-1:0] r_out_total;

    ket_seq #(
        .ENTRIES (ENTRIES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_done      (done),
        .i_out_free  (out_free)
    );

    ket_ram #(
        .WIDTH (KET_ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || o_rsp.ready;

    // Track output register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= done.valid;
        end
    end

    // Load the result when the register is free
    always_ff @(posedge i_clk) begin
        if (out_free && done.valid) begin
            r_out_found  <= done.found;
            r_out_status <= done.status;
            r_out_bytes  <= done.bytes;
            r_out_path   <= done.path;
            r_out_total  <= done.total;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.found           = r_out_found;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.byte_count_out  = r_out_bytes;
    assign o_rsp.path_handle_out = r_out_path;
    assign o_rsp.entry_total     = r_out_total;

    // Only a hit reports found, and a hit always reports the hit status
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_found == (r_out_status == ST_HIT)))
        else $error("found flag disagrees with status");

    // A miss returns zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_bytes == '0 && r_out_path == '0))
        else $error("miss result carries stored data");

    // A stalled result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out_total)))
        else $error("stalled result overwritten");

endmodule
